>>> rtl/xxh_pkg.sv
// Package for the streaming 64-bit hash block: primes, widths and the
// controller-to-datapath command type. No dependencies.
package xxh_pkg;
   localparam int LENGTH_BITS = 64;
   localparam logic [63:0] PR1 = 64'd14029467366897019727;
   localparam logic [63:0] PR2 = 64'd11400714785074694791;
   localparam logic [63:0] PR3 = 64'd9650029242287828579;
   localparam logic [63:0] PR4 = 64'd1609587929392839161;
   localparam logic [63:0] PR5 = 64'd2870177450012600261;

   // Multiplier operand selects.
   typedef enum logic [2:0] {
      MA_WORD = 3'd0, MA_ACC = 3'd1, MA_H = 3'd2, MA_T = 3'd3, MA_LOW = 3'd4,
      MA_BYTE = 3'd5
   } mula_type;

   typedef enum logic [3:0] {
      OP_NONE = 4'd0, OP_LOAD = 4'd1, OP_RND1 = 4'd2, OP_RND2 = 4'd3,
      OP_MSUM = 4'd4, OP_MRG1 = 4'd5, OP_MRG2 = 4'd6, OP_MRG3 = 4'd7,
      OP_LEN = 4'd8, OP_F8_3 = 4'd9, OP_F4_1 = 4'd10, OP_F4_2 = 4'd11,
      OP_F1_1 = 4'd12, OP_F1_2 = 4'd13, OP_AV1 = 4'd14, OP_AV2 = 4'd15
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] lane;   // lane or buffer index
      logic [2:0] pos;    // byte position in the last word
      logic       src_w;  // 8-byte fold takes the held word, not a buffer entry
      logic       src_l;  // multiplier takes the lane accumulator
      logic       clear;  // return lanes, fill, seen flag and length to reset values
      logic       emit;   // move the finished hash into the output register
   } cmd_type;

   typedef struct packed {
      logic [1:0] fill;
      logic       seen;
      logic [3:0] count;
   } stat_type;
endpackage

>>> rtl/xxh_stream_if.sv
// Valid/ready channel interface for the hash block. Uses nothing else.
interface xxh_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  byte_count;
   logic        last;
   modport source (output valid, data_word, byte_count, last, input ready);
   modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface xxh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

>>> rtl/xxh64_stream_hash.sv
// Top level of the streaming 64-bit hash (seed zero); joins controller and datapath.
// Depends on xxh_pkg, xxh_req_if, xxh_rsp_if, xxh_control and xxh_datapath.
//
// Usage: feed a message on req as 64-bit little-endian words; every word but
// the last carries eight bytes, the last carries 0 to 8 bytes in byte_count.
// One item is taken at a time. A word that only fills the stripe buffer
// is decoded and loaded into it; a word that completes a 32-byte stripe
// also runs the eight multiply steps of the four lane rounds on the single
// shared 64-bit multiplier. The last item additionally runs the lane merge
// when a stripe was seen, the length add, MRG1/MRG2/F8_3 per leftover
// 8-byte word, F4_1/F4_2 for a 4-byte word, F1_1/F1_2 per single byte, a
// closing step unless a full last word was folded, AV1/AV2 for the avalanche
// and the move into the output register; rsp presents the hash the cycle after.
// While that hash waits on a stalled rsp, the block goes on taking the next
// message and holds before handing off its hash until the first is taken.
// Reset is synchronous; it returns the lanes, the length and the controller
// to their start values, ready for a new message.
module xxh64_stream_hash (
   input logic clock,
   input logic reset,
   xxh_req_if.sink   req,
   xxh_rsp_if.source rsp
);
   import xxh_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     take;

   xxh_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .req_last(req.last), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd), .take(take)
   );

   xxh_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_take(take),
      .in_word(req.data_word), .in_count(req.byte_count), .in_last(req.last),
      .stat(stat), .hash(rsp.hash_value)
   );
endmodule

>>> rtl/xxh_datapath.sv
// Datapath: lanes, stripe buffer, length, one shared 64-bit multiplier built
// from 32-bit products, and the output register. Depends on xxh_pkg.
module xxh_datapath (
   input  logic             clock,
   input  logic             reset,
   input  xxh_pkg::cmd_type cmd,
   input  logic             in_take,
   input  logic [63:0]      in_word,
   input  logic [3:0]       in_count,
   input  logic             in_last,
   output xxh_pkg::stat_type stat,
   output logic [63:0]      hash
);
   import xxh_pkg::*;

   logic [63:0] lane_ff [4];
   logic [63:0] lane_in [4];
   logic [63:0] buf_ff [3];
   logic [1:0]  fill_ff, fill_in;
   logic        seen_ff, seen_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [63:0] word_ff;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] t_ff, t_in;
   logic [63:0] out_ff;
   logic [63:0] ma, mb, prod;
   logic [63:0] lo_prod;
   logic [31:0] cross_a, cross_b;
   logic [63:0] buf_sel;

   function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
      rotl = (v << r) | (v >> (64 - r));
   endfunction

   assign buf_sel = (cmd.src_w || cmd.lane == 2'd3) ? word_ff : buf_ff[cmd.lane];

   // Low 64 bits of the product from one full and two truncated 32-bit products.
   assign lo_prod = ma[31:0] * mb[31:0];
   assign cross_a = ma[63:32] * mb[31:0];
   assign cross_b = ma[31:0] * mb[63:32];
   assign prod = lo_prod + {cross_a + cross_b, 32'd0};

   always_comb begin
      ma = buf_sel;
      mb = PR1;
      unique case (cmd.op)
         OP_RND2: begin
            ma = rotl(t_ff, 31);
            mb = PR2;
         end
         OP_MRG1: ma = cmd.src_l ? lane_ff[cmd.lane] : buf_sel;
         OP_MRG2: begin
            ma = t_ff;
            mb = PR2;
         end
         OP_MRG3: begin
            ma = h_ff;
            mb = PR2;
         end
         OP_F8_3: begin
            ma = rotl(h_ff, 27);
            mb = PR2;
         end
         OP_F4_1: begin
            ma = {32'd0, word_ff[31:0]};
            mb = PR2;
         end
         OP_F4_2: begin
            ma = rotl(h_ff, 23);
            mb = PR1;
         end
         OP_F1_1: begin
            ma = {56'd0, word_ff[8*cmd.pos +: 8]};
            mb = PR5;
         end
         OP_F1_2: begin
            ma = rotl(h_ff, 11);
            mb = PR2;
         end
         OP_AV1: begin
            ma = h_ff ^ (h_ff >> 33);
            mb = PR1;
         end
         OP_AV2: begin
            ma = t_ff ^ (t_ff >> 29);
            mb = PR4;
         end
         OP_RND1: ma = (cmd.src_w) ? buf_sel : buf_sel;
         default: ma = buf_sel;
      endcase
   end

   always_comb begin
      lane_in = lane_ff;
      fill_in = fill_ff;
      seen_in = seen_ff;
      len_in  = len_ff;
      cnt_in  = cnt_ff;
      h_in    = h_ff;
      t_in    = prod;
      if (in_take) begin
         cnt_in = (!in_last || in_count > 4'd8) ? 4'd8 : in_count;
         len_in = len_ff + LENGTH_BITS'(cnt_in);
      end
      unique case (cmd.op)
         OP_RND1: t_in = lane_ff[cmd.lane] + prod;
         OP_RND2: begin
            // First pass: lane round. Reuse of OP_RND2 for merge is not done.
            t_in = prod;
         end
         OP_MSUM: h_in = rotl(lane_ff[0], 1) + rotl(lane_ff[1], 7)
                       + rotl(lane_ff[2], 12) + rotl(lane_ff[3], 18);
         OP_MRG1: t_in = rotl(prod, 31);
         OP_MRG2: h_in = h_ff ^ prod;
         OP_MRG3: h_in = prod + PR3;
         OP_LEN: h_in = (seen_ff ? h_ff : PR5) + 64'(len_ff);
         OP_F8_3: h_in = prod + PR3;
         OP_F4_1: h_in = h_ff ^ prod;
         OP_F4_2: h_in = prod + PR4;
         OP_F1_1: h_in = h_ff ^ prod;
         OP_F1_2: h_in = prod;
         OP_AV1: t_in = prod;
         OP_AV2: h_in = prod ^ (prod >> 32);
         default: ;
      endcase
      if (cmd.op == OP_RND2 && !cmd.src_w) begin
         lane_in[cmd.lane] = prod;
         if (cmd.lane == 2'd3) begin
            seen_in = 1'b1;
            fill_in = 2'd0;
            cnt_in  = 4'd0;
         end
      end
      if (cmd.op == OP_LOAD) fill_in = fill_ff + 2'd1;
      if (cmd.clear) begin
         lane_in[0] = PR1 + PR2;
         lane_in[1] = PR1;
         lane_in[2] = 64'd0;
         lane_in[3] = 64'd0 - PR2;
         fill_in = 2'd0;
         seen_in = 1'b0;
         len_in  = '0;
      end
   end

   // Lane rounds: RND1 gives t = lane + w*P1 for every lane index.
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff[0] <= PR1 + PR2;
         lane_ff[1] <= PR1;
         lane_ff[2] <= 64'd0;
         lane_ff[3] <= 64'd0 - PR2;
         fill_ff <= 2'd0;
         seen_ff <= 1'b0;
         len_ff  <= '0;
         cnt_ff  <= 4'd0;
      end else begin
         lane_ff <= lane_in;
         fill_ff <= fill_in;
         seen_ff <= seen_in;
         len_ff  <= len_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) word_ff <= in_word;
      if (cmd.op == OP_LOAD) buf_ff[fill_ff] <= word_ff;
      if (cmd.emit) out_ff <= (h_ff == 64'd0) ? 64'd1 : h_ff;
      h_ff <= h_in;
      t_ff <= t_in;
   end

   assign stat = '{fill: fill_ff, seen: seen_ff, count: cnt_ff};
   assign hash = out_ff;
endmodule

>>> rtl/xxh_control.sv
// Controller: sequences lane rounds and the finishing steps over the datapath.
// Depends on xxh_pkg.
module xxh_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  xxh_pkg::stat_type stat,
   output xxh_pkg::cmd_type  cmd,
   output logic              take
);
   import xxh_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_DEC = 7'b0000010, S_RND = 7'b0000100,
      S_MRG = 7'b0001000, S_TAIL = 7'b0010000, S_AV = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic [2:0]  ph_ff, ph_in;
   logic [2:0]  pos_ff, pos_in;
   logic        last_ff, last_in;
   logic        w4_ff, w4_in;
   logic        rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      ph_in = ph_ff;
      pos_in = pos_ff;
      last_in = last_ff;
      w4_in = w4_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '{op: OP_NONE, lane: idx_ff, pos: pos_ff, src_w: 1'b0, src_l: 1'b0,
              clear: 1'b0, emit: 1'b0};
      unique case (state_ff)
         S_IDLE: if (take) begin
            last_in = req_last;
            state_in = S_DEC;
         end
         S_DEC: begin
            idx_in = 2'd0;
            ph_in = 3'd0;
            if (stat.count == 4'd8 && stat.fill == 2'd3) state_in = S_RND;
            else if (!last_ff) begin
               if (stat.count == 4'd8) cmd.op = OP_LOAD;
               state_in = S_IDLE;
            end else state_in = S_MRG;
         end
         S_RND: begin
            cmd.op = ph_ff[0] ? OP_RND2 : OP_RND1;
            cmd.lane = idx_ff;
            if (ph_ff[0] == 1'b0) begin
               ph_in = 3'd1;
            end else if (ph_ff[1] == 1'b0) begin
               ph_in = 3'd0;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = last_ff ? S_MRG : S_IDLE;
                  idx_in = 2'd0;
               end
            end
         end
         S_MRG: begin
            if (!stat.seen) begin
               cmd.op = OP_LEN;
               state_in = S_TAIL;
               ph_in = 3'd0;
               idx_in = 2'd0;
            end else if (ph_ff == 3'd0) begin
               cmd.op = OP_MSUM;
               ph_in = 3'd1;
            end else begin
               cmd.lane = idx_ff;
               cmd.src_w = 1'b0;
               unique case (ph_ff)
                  3'd1: cmd.op = OP_NONE;
                  default: cmd.op = OP_NONE;
               endcase
               // merge uses mix_round(0, lane): lane*P1, rotate, *P2.
               unique case (ph_ff)
                  3'd1: begin
                     cmd.op = OP_MRG1;
                     cmd.src_l = 1'b1;
                     ph_in = 3'd2;
                  end
                  3'd2: begin
                     cmd.op = OP_MRG2;
                     ph_in = 3'd3;
                  end
                  3'd3: begin
                     cmd.op = OP_MRG3;
                     ph_in = 3'd1;
                     idx_in = idx_ff + 2'd1;
                     if (idx_ff == 2'd3) begin
                        ph_in = 3'd4;
                        idx_in = 2'd0;
                     end
                  end
                  default: begin
                     cmd.op = OP_LEN;
                     ph_in = 3'd0;
                     state_in = S_TAIL;
                  end
               endcase
            end
            w4_in = 1'b0;
            pos_in = 3'd0;
         end
         S_TAIL: begin
            cmd.lane = idx_ff;
            cmd.pos = pos_ff;
            if ({1'b0, idx_ff} < {1'b0, stat.fill} ||
                (stat.count == 4'd8 && idx_ff == stat.fill)) begin
               // fold_word8: MRG1 (w*P1 rot31), MRG2 (*P2 xor), F8_3.
               cmd.src_w = (idx_ff == stat.fill);
               unique case (ph_ff)
                  3'd0: begin
                     cmd.op = OP_MRG1;
                     ph_in = 3'd1;
                  end
                  3'd1: begin
                     cmd.op = OP_MRG2;
                     ph_in = 3'd2;
                  end
                  default: begin
                     cmd.op = OP_F8_3;
                     ph_in = 3'd0;
                     idx_in = idx_ff + 2'd1;
                     if (idx_ff == stat.fill) state_in = S_AV;
                  end
               endcase
            end else if (stat.count == 4'd8 || stat.count < 4'd4 || w4_ff) begin
               if ({1'b0, pos_ff} < stat.count && stat.count != 4'd8) begin
                  cmd.op = ph_ff[0] ? OP_F1_2 : OP_F1_1;
                  ph_in = {2'b00, ~ph_ff[0]};
                  if (ph_ff[0]) pos_in = pos_ff + 3'd1;
               end else begin
                  state_in = S_AV;
                  ph_in = 3'd0;
               end
            end else begin
               cmd.op = ph_ff[0] ? OP_F4_2 : OP_F4_1;
               ph_in = {2'b00, ~ph_ff[0]};
               if (ph_ff[0]) begin
                  w4_in = 1'b1;
                  pos_in = 3'd4;
               end
            end
         end
         S_AV: begin
            cmd.op = ph_ff[0] ? OP_AV2 : OP_AV1;
            ph_in = {2'b00, ~ph_ff[0]};
            if (ph_ff[0]) begin
               cmd.clear = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: if (!rsp_valid_ff || rsp_ready) begin
            cmd.emit = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= 2'd0;
         ph_ff <= 3'd0;
         pos_ff <= 3'd0;
         last_ff <= 1'b0;
         w4_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         ph_ff <= ph_in;
         pos_ff <= pos_in;
         last_ff <= last_in;
         w4_ff <= w4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
